@@ design/bba_pkg.sv @@
package bba_pkg;

  // Default geometry of the map
  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 12;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 13;
  localparam int CFG_W     = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_FORMAT = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_DIV,
    S_FREE_MOD,
    S_FREE_RD,
    S_FREE_CHK,
    S_FORMAT
  } state_t;

  // Result to post this cycle, if any
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALLOC,
    RES_FULL,
    RES_FREE_OK,
    RES_FREE_BAD,
    RES_FORMAT,
    RES_NOP
  } res_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;       // capture request fields
    logic    scan_init;  // rewind the word pointer for a search
    logic    scan_rd;    // read the next word of the search
    logic    free_div;   // estimate word number of the freed block
    logic    free_mod;   // correct word number, form bit number
    logic    free_rd;    // read the word that holds the freed block
    logic    fmt_init;   // rewind the word pointer, latch the reservation
    logic    fmt_wr;     // write one word of the format pattern
    res_op_t res;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // word just read has a free block
    logic scan_end;  // word just read is the last one
    logic fmt_last;  // format pointer sits on the last word
    logic free_ok;   // freed block is in range and in use
  } dp_status_t;

endpackage

@@ design/bba_ctrl.sv @@
module bba_ctrl
  import bba_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KIND_W-1:0]   in_kind,
  input  dp_status_t          dp_st,
  output ctrl_cmd_t           cmd,
  output logic                busy
);

  state_t state_r, state_nxt;

  // Hold state; a clearing pass runs after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = RES_NONE;
    busy      = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.fmt_wr = 1'b1;
        if (dp_st.fmt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_ALLOC: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
            KIND_FREE: begin
              state_nxt = S_FREE_DIV;
            end
            KIND_FORMAT: begin
              cmd.fmt_init = 1'b1;
              state_nxt    = S_FORMAT;
            end
            KIND_NOP: begin
              cmd.res = RES_NOP;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        priority if (dp_st.hit) begin
          cmd.res   = RES_ALLOC;
          state_nxt = S_IDLE;
        end else if (dp_st.scan_end) begin
          cmd.res   = RES_FULL;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FREE_DIV: begin
        cmd.free_div = 1'b1;
        state_nxt    = S_FREE_MOD;
      end
      S_FREE_MOD: begin
        cmd.free_mod = 1'b1;
        state_nxt    = S_FREE_RD;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.res   = dp_st.free_ok ? RES_FREE_OK : RES_FREE_BAD;
        state_nxt = S_IDLE;
      end
      S_FORMAT: begin
        cmd.fmt_wr = 1'b1;
        if (dp_st.fmt_last) begin
          cmd.res   = RES_FORMAT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bba_dpath.sv @@
module bba_dpath
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           dp_st,
  input  logic [IDX_W-1:0]     in_block_index,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_strobe,
  output logic [IDX_W-1:0]     out_alloc_index,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CNT_OUT_W-1:0] out_used_count
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(MAP_WORDS + 1);
  localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] PAD_MASK =
    ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
  // Reciprocal for block number to word number
  localparam int DIV_SH = IDX_W + 7;
  localparam int DIV_M  = (1 << DIV_SH) / WORD_BITS;
  localparam int PROD_W = IDX_W + DIV_SH;

  // Bitmap storage
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [CFG_W-1:0]  reserved_r;
  logic [CNT_W-1:0]  rsat_r, rsat_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  q_r;
  logic [BW-1:0]     bit_r;
  logic [PW-1:0]     ptr_r;
  logic [BASE_W-1:0] base_r;
  logic              rdv_r;
  logic [AW-1:0]     rd_word_r;
  logic [BASE_W-1:0] rd_base_r;

  logic                 out_strobe_r;
  logic [IDX_W-1:0]     out_idx_r;
  status_t              out_status_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic                 ptr_live;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] fmt_pat;
  logic [WORD_BITS-1:0] scan_word;
  logic [BW-1:0]        free_pos;
  logic                 idx_in_range;
  logic [PROD_W-1:0]    div_prod;
  logic [IDX_W-1:0]     rem;
  logic [BASE_W-1:0]    rsat_x;
  logic [BASE_W-1:0]    base_end;
  logic [BW-1:0]        fmt_fill;
  logic [31:0]          res_ext;

  assign ptr_live     = ptr_r < PW'(MAP_WORDS);
  assign idx_in_range = 32'(idx_r) < 32'(NUM_BLOCKS);

  // Status toward the controller
  assign scan_word      = rd_data_r |
                          ((rd_word_r == AW'(MAP_WORDS - 1)) ? PAD_MASK : '0);
  assign dp_st.hit      = rdv_r && !(&scan_word);
  assign dp_st.scan_end = rdv_r && (rd_word_r == AW'(MAP_WORDS - 1));
  assign dp_st.fmt_last = ptr_r == PW'(MAP_WORDS - 1);
  assign dp_st.free_ok  = idx_in_range && rd_data_r[bit_r];

  // Lowest free block in the word just read
  always_comb begin
    free_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        free_pos = BW'(b);
      end
    end
  end

  // Format pattern for the word at the pointer
  assign rsat_x   = BASE_W'(rsat_r);
  assign base_end = base_r + BASE_W'(WORD_BITS);
  assign fmt_fill = BW'(rsat_x - base_r);
  always_comb begin
    priority if (rsat_x >= base_end) begin
      fmt_pat = '1;
    end else if (rsat_x <= base_r) begin
      fmt_pat = '0;
    end else begin
      fmt_pat = ~({WORD_BITS{1'b1}} << fmt_fill);
    end
  end

  // Saturate the reservation to the map size
  assign res_ext  = 32'(reserved_r);
  assign rsat_nxt = (res_ext > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(res_ext);

  // Word number estimate and remainder
  assign div_prod = PROD_W'(idx_r) * PROD_W'(DIV_M);
  assign rem      = idx_r - q_r * IDX_W'(WORD_BITS);

  // Memory port selection
  assign rd_en   = (cmd.scan_rd && ptr_live) || (cmd.free_rd && idx_in_range);
  assign rd_addr = cmd.free_rd ? q_r[AW-1:0] : ptr_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_data = fmt_pat;
    priority if (cmd.fmt_wr) begin
      wr_en = 1'b1;
    end else if (cmd.res == RES_ALLOC) begin
      wr_en   = 1'b1;
      wr_addr = rd_word_r;
      wr_data = rd_data_r | (WORD_BITS'(1) << free_pos);
    end else if (cmd.res == RES_FREE_OK) begin
      wr_en   = 1'b1;
      wr_addr = q_r[AW-1:0];
      wr_data = rd_data_r & ~(WORD_BITS'(1) << bit_r);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
    end
  end

  // Next used count
  always_comb begin
    used_nxt = used_r;
    unique case (cmd.res)
      RES_ALLOC:   used_nxt = used_r + CNT_W'(1);
      RES_FREE_OK: used_nxt = (used_r != '0) ? used_r - CNT_W'(1) : used_r;
      RES_FORMAT:  used_nxt = rsat_r;
      RES_NONE, RES_FULL, RES_FREE_BAD, RES_NOP: used_nxt = used_r;
      default:     used_nxt = used_r;
    endcase
  end

  // Control registers: pointer, base, count, reservation, read valid and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r   <= '0;
      rsat_r       <= '0;
      used_r       <= '0;
      ptr_r        <= '0;
      base_r       <= '0;
      rdv_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        reserved_r <= cfg_wdata;
      end
      used_r       <= used_nxt;
      out_strobe_r <= cmd.res != RES_NONE;
      rdv_r        <= cmd.scan_rd && ptr_live;
      if (cmd.fmt_init) begin
        rsat_r <= rsat_nxt;
      end
      priority if (cmd.scan_init || cmd.fmt_init) begin
        ptr_r  <= '0;
        base_r <= '0;
      end else if (cmd.fmt_wr || (cmd.scan_rd && ptr_live)) begin
        ptr_r  <= ptr_r + PW'(1);
        base_r <= base_end;
      end else begin
        ptr_r  <= ptr_r;
        base_r <= base_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_block_index;
    end
    if (cmd.scan_rd && ptr_live) begin
      rd_word_r <= ptr_r[AW-1:0];
      rd_base_r <= base_r;
    end
    if (cmd.free_div) begin
      q_r <= IDX_W'(div_prod >> DIV_SH);
    end
    if (cmd.free_mod) begin
      if (rem >= IDX_W'(WORD_BITS)) begin
        q_r   <= q_r + IDX_W'(1);
        bit_r <= BW'(rem - IDX_W'(WORD_BITS));
      end else begin
        bit_r <= BW'(rem);
      end
    end
    if (cmd.res != RES_NONE) begin
      out_cnt_r    <= CNT_OUT_W'(used_nxt);
      out_idx_r    <= (cmd.res == RES_ALLOC) ? IDX_W'(rd_base_r + BASE_W'(free_pos)) : '0;
      unique case (cmd.res)
        RES_FULL:     out_status_r <= STAT_FULL;
        RES_FREE_BAD: out_status_r <= STAT_BAD_FREE;
        default:      out_status_r <= STAT_OK;
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_alloc_index = out_idx_r;
  assign out_status      = out_status_r;
  assign out_used_count  = out_cnt_r;

endmodule

@@ design/bitmap_block_allocator.sv @@
// First-fit bitmap block allocator. A request (allocate, free or format) is
// taken when start is high and busy is low; each request posts exactly one
// result, on out_strobe for a single cycle, and the receiver cannot stall it.
// Allocate walks the map one word per cycle through the map memory's read
// port until it finds a free block or reaches the last word. Format writes
// every map word, one per cycle. Free estimates the word number, corrects
// it and forms the bit number, reads the word and checks the block; the unused
// request kind posts its result on the next cycle without raising busy.
// After reset the block clears the map with busy high; reserved_count may be
// written at any time the block is idle and takes effect at the next format.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [IDX_W-1:0]     in_block_index,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_strobe,
  output logic [IDX_W-1:0]     out_alloc_index,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CNT_OUT_W-1:0] out_used_count
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  // Sequence the request
  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .dp_st   (dp_st),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Map, counters and result registers
  bba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_st           (dp_st),
    .in_block_index  (in_block_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_alloc_index (out_alloc_index),
    .out_status      (out_status),
    .out_used_count  (out_used_count)
  );

endmodule
